// ----- hw/rtl/uer_pkg.sv -----
// Shared types and constants for the three-channel echo ranging block.
package uer_pkg;

  localparam int unsigned NumLanes        = 3;
  localparam int unsigned TimeBitsDefault = 16;
  localparam int unsigned TickWidth       = 8;
  localparam int unsigned RespWidth       = 16;
  localparam int unsigned ScaleWidth      = 16;
  localparam int unsigned DistWidth       = 11;
  localparam int unsigned ScaleShift      = 20;
  localparam int unsigned DistMax         = 2047;
  localparam int unsigned CfgIdxWidth     = 2;
  localparam int unsigned CfgDataWidth    = 16;

  localparam logic [TickWidth-1:0]  TickPeriodReset = 8'd30;
  localparam logic [RespWidth-1:0]  TimeoutReset    = 16'd25000;
  localparam logic [ScaleWidth-1:0] ScaleReset      = 16'd17983;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_TICK_PERIOD = 2'd0,
    CFG_TIMEOUT     = 2'd1,
    CFG_SCALE       = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic accept;
    logic trigger;
    logic sample;
  } lane_ctrl_t;

endpackage

// ----- hw/rtl/uer_lane.sv -----
// One echo channel: pulse tracking, saturating echo time and falling-edge capture.
module uer_lane #(
  parameter int unsigned TimeBits = uer_pkg::TimeBitsDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  uer_pkg::lane_ctrl_t            ctrl_i,
  input  logic                           level_i,
  input  logic [uer_pkg::TickWidth-1:0]  tick_period_i,
  output logic                           done_o,
  output logic [TimeBits-1:0]            time_o
);
  import uer_pkg::*;

  logic                started_q, started_d;
  logic [TimeBits-1:0] time_q, time_d;
  logic                done_q, done_d;
  logic [TimeBits-1:0] snap_q;
  logic [TimeBits:0]   sum;
  logic [TimeBits-1:0] time_sat;

  assign sum      = {1'b0, time_q} + (TimeBits+1)'(tick_period_i);
  assign time_sat = sum[TimeBits] ? '1 : sum[TimeBits-1:0];

  always_comb begin
    started_d = started_q;
    time_d    = time_q;
    done_d    = 1'b0;
    if (ctrl_i.trigger) begin
      time_d = '0;
    end else if (ctrl_i.sample) begin
      if (!started_q && level_i) begin
        started_d = 1'b1;
      end else if (started_q && level_i) begin
        time_d = time_sat;
      end else if (started_q && !level_i) begin
        started_d = 1'b0;
        done_d    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      time_q    <= '0;
      done_q    <= 1'b0;
    end else if (ctrl_i.accept) begin
      started_q <= started_d;
      time_q    <= time_d;
      done_q    <= done_d;
    end
  end

  // time as it stood before the last accepted item: the pulse-end time when done is set
  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) begin
      snap_q <= time_q;
    end
  end

  assign done_o = done_q;
  assign time_o = snap_q;

endmodule

// ----- hw/rtl/uer_merge.sv -----
// Merge stage: scales captured lane times to distances and holds the result register.
module uer_merge #(
  parameter int unsigned TimeBits = uer_pkg::TimeBitsDefault
) (
  input  logic                                                clk_i,
  input  logic                                                rst_ni,
  input  logic                                                in_valid_i,
  output logic                                                in_ready_o,
  input  logic [uer_pkg::NumLanes-1:0]                        done_i,
  input  logic [uer_pkg::NumLanes-1:0][TimeBits-1:0]          time_i,
  input  logic                                                listen_i,
  input  logic [uer_pkg::ScaleWidth-1:0]                      scale_i,
  output logic                                                out_valid_o,
  input  logic                                                out_stall_i,
  output logic [uer_pkg::NumLanes-1:0][uer_pkg::DistWidth-1:0] distance_o,
  output logic [uer_pkg::NumLanes-1:0]                        done_o,
  output logic                                                listen_o
);
  import uer_pkg::*;

  localparam int unsigned ProdWidth = TimeBits + ScaleWidth;

  logic                                 load;
  logic                                 valid_q;
  logic [NumLanes-1:0]                  done_q;
  logic                                 listen_q;
  logic [NumLanes-1:0][DistWidth-1:0]   dist_q, dist_d;
  logic [NumLanes-1:0][ProdWidth-1:0]   prod;
  logic [NumLanes-1:0][ProdWidth-1:0]   shifted;

  assign in_ready_o = !valid_q || !out_stall_i;
  assign load       = in_valid_i && in_ready_o;

  for (genvar l = 0; l < NumLanes; l++) begin : g_scale
    assign prod[l]    = ProdWidth'(time_i[l]) * ProdWidth'(scale_i);
    assign shifted[l] = prod[l] >> ScaleShift;
    always_comb begin
      dist_d[l] = dist_q[l];
      if (done_i[l]) begin
        if (shifted[l] > ProdWidth'(DistMax)) begin
          dist_d[l] = DistWidth'(DistMax);
        end else begin
          dist_d[l] = shifted[l][DistWidth-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      dist_q   <= '0;
      done_q   <= '0;
      listen_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        valid_q <= in_valid_i;
      end
      if (load) begin
        dist_q   <= dist_d;
        done_q   <= done_i;
        listen_q <= listen_i;
      end
    end
  end

  assign out_valid_o = valid_q;
  assign distance_o  = dist_q;
  assign done_o      = done_q;
  assign listen_o    = listen_q;

endmodule

// ----- hw/rtl/ultrasonic_echo_ranging.sv -----
// Top level of the three-channel ultrasonic echo pulse-width ranging block.
//
// Input channel (in_valid_i / in_stall_o): one transfer per item. kind_i = 0
// is a trigger that clears the echo times and the response timer and starts
// listening; kind_i = 1 is a tick that samples echo_a_i..echo_c_i while listening.
// Output channel (out_valid_o / out_stall_i): one result per item with the
// three latched distances in cm, per-channel done flags and the listen flag.
// Config channel (cfg_valid_i / cfg_ready_o): cfg_index_i selects tick period
// (0), timeout (1) or distance scale (2); cfg_ready_o is always high. Write
// only while no item is in flight.
// An input transfer is registered in the three channel lanes, then in the merge
// stage whose multiplier per lane turns the captured echo time into a distance.
// One item per cycle is sustained while the receiver does not stall.
// When the receiver stalls, the result register holds, the lane capture
// register fills behind it, and in_stall_o rises only when both are full.
// Reset sets idle, not listening, distances zero, config to defaults; lane time snapshots are not reset.
module ultrasonic_echo_ranging #(
  parameter int unsigned TimeBits = uer_pkg::TimeBitsDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              kind_i,
  input  logic                              echo_a_i,
  input  logic                              echo_b_i,
  input  logic                              echo_c_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [uer_pkg::DistWidth-1:0]     distance_a_o,
  output logic [uer_pkg::DistWidth-1:0]     distance_b_o,
  output logic [uer_pkg::DistWidth-1:0]     distance_c_o,
  output logic                              done_a_o,
  output logic                              done_b_o,
  output logic                              done_c_o,
  output logic                              listening_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [uer_pkg::CfgIdxWidth-1:0]   cfg_index_i,
  input  logic [uer_pkg::CfgDataWidth-1:0]  cfg_data_i
);
  import uer_pkg::*;

  logic [TickWidth-1:0]  tick_period_q;
  logic [RespWidth-1:0]  timeout_q;
  logic [ScaleWidth-1:0] scale_q;

  logic                  accept;
  logic                  s1_valid_q;
  logic                  s1_listen_q;
  logic                  merge_ready;
  logic                  listen_q, listen_d;
  logic [RespWidth-1:0]  resp_q, resp_d;
  logic [RespWidth:0]    resp_sum;
  lane_ctrl_t            lane_ctrl;

  logic [NumLanes-1:0]                 levels;
  logic [NumLanes-1:0]                 lane_done;
  logic [NumLanes-1:0][TimeBits-1:0]   lane_time;
  logic [NumLanes-1:0][DistWidth-1:0]  distance;
  logic [NumLanes-1:0]                 done;

  // config registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_period_q <= TickPeriodReset;
      timeout_q     <= TimeoutReset;
      scale_q       <= ScaleReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_TICK_PERIOD: tick_period_q <= cfg_data_i[TickWidth-1:0];
        CFG_TIMEOUT:     timeout_q     <= cfg_data_i[RespWidth-1:0];
        CFG_SCALE:       scale_q       <= cfg_data_i[ScaleWidth-1:0];
        default:         ;
      endcase
    end
  end

  // handshake: lane capture register moves into the merge stage when it frees up
  assign in_stall_o = s1_valid_q && !merge_ready;
  assign accept     = in_valid_i && !in_stall_o;

  // listen flag and response timer
  assign resp_sum = {1'b0, resp_q} + (RespWidth+1)'(tick_period_q);

  always_comb begin
    listen_d = listen_q;
    resp_d   = resp_q;
    if (!kind_i) begin
      listen_d = 1'b1;
      resp_d   = '0;
    end else if (listen_q) begin
      if (resp_q > timeout_q) begin
        listen_d = 1'b0;
      end
      resp_d = resp_sum[RespWidth] ? '1 : resp_sum[RespWidth-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      listen_q    <= 1'b0;
      resp_q      <= '0;
      s1_valid_q  <= 1'b0;
      s1_listen_q <= 1'b0;
    end else begin
      if (accept) begin
        listen_q    <= listen_d;
        resp_q      <= resp_d;
        s1_listen_q <= listen_d;
      end
      if (!in_stall_o) begin
        s1_valid_q <= in_valid_i;
      end
    end
  end

  assign lane_ctrl.accept  = accept;
  assign lane_ctrl.trigger = accept && !kind_i;
  assign lane_ctrl.sample  = accept && kind_i && listen_q;

  assign levels = {echo_c_i, echo_b_i, echo_a_i};

  for (genvar l = 0; l < NumLanes; l++) begin : g_lane
    uer_lane #(
      .TimeBits(TimeBits)
    ) u_lane (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (lane_ctrl),
      .level_i      (levels[l]),
      .tick_period_i(tick_period_q),
      .done_o       (lane_done[l]),
      .time_o       (lane_time[l])
    );
  end

  uer_merge #(
    .TimeBits(TimeBits)
  ) u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s1_valid_q),
    .in_ready_o (merge_ready),
    .done_i     (lane_done),
    .time_i     (lane_time),
    .listen_i   (s1_listen_q),
    .scale_i    (scale_q),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .distance_o (distance),
    .done_o     (done),
    .listen_o   (listening_o)
  );

  assign distance_a_o = distance[0];
  assign distance_b_o = distance[1];
  assign distance_c_o = distance[2];
  assign done_a_o     = done[0];
  assign done_b_o     = done[1];
  assign done_c_o     = done[2];

`ifndef ASSERT_OFF
  a_idle_tick_no_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && kind_i && !listen_q) |=> (lane_done == '0))
    else $error("lane reported done on a tick taken while not listening");

  a_timer_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && kind_i) |=> (resp_q >= $past(resp_q)))
    else $error("response timer went backward on a tick");

  a_trigger_listens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !kind_i) |=> (listen_q && s1_listen_q && resp_q == '0))
    else $error("trigger did not start listening");
`endif

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for ultrasonic_echo_ranging: random ping sequences with a predictor.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import uer_pkg::*;

  localparam logic KindTrigger  = 1'b0;
  localparam logic KindTick     = 1'b1;
  localparam int   TimeW        = TimeBitsDefault;
  localparam int   HoldCycles   = 200;
  localparam int   PhaseItems   = 40;
  localparam int   SettleCycles = 4;

  typedef struct packed {
    logic [NumLanes-1:0][DistWidth-1:0] cm;
    logic [NumLanes-1:0]                done;
    logic                               listening;
  } ranging_result_t;

  class ranging_scoreboard;
    logic [TickWidth-1:0]               tick_us;
    logic [RespWidth-1:0]               limit_us;
    logic [ScaleWidth-1:0]              scale;
    logic [NumLanes-1:0]                in_pulse;
    logic [NumLanes-1:0][TimeW-1:0]     echo_us;
    logic [NumLanes-1:0][DistWidth-1:0] dist_cm;
    logic [RespWidth-1:0]               resp_us;
    logic                               listen;
    ranging_result_t                    ranging_q[$];
    int unsigned failures, n_checked, n_latched, n_timeouts;

    function new();
      tick_us    = TickPeriodReset;
      limit_us   = TimeoutReset;
      scale      = ScaleReset;
      in_pulse   = '0;
      echo_us    = '0;
      dist_cm    = '0;
      resp_us    = '0;
      listen     = 1'b0;
      failures   = 0;
      n_checked  = 0;
      n_latched  = 0;
      n_timeouts = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [CfgDataWidth-1:0] data);
      case (idx)
        CFG_TICK_PERIOD: tick_us = data[TickWidth-1:0];
        CFG_TIMEOUT:     limit_us = data;
        CFG_SCALE:       scale = data;
        default: ;
      endcase
    endfunction

    function void note_input(logic kind, logic [NumLanes-1:0] level);
      ranging_result_t             r;
      logic [TimeW:0]              esum;
      logic [RespWidth:0]          rsum;
      logic [TimeW+ScaleWidth-1:0] prod;
      r.done = '0;
      if (kind == KindTrigger) begin
        echo_us = '0;
        resp_us = '0;
        listen  = 1'b1;
      end else if (listen) begin
        if (resp_us > limit_us) begin
          listen = 1'b0;
          n_timeouts++;
        end
        for (int i = 0; i < NumLanes; i++) begin
          if (!in_pulse[i] && level[i]) begin
            in_pulse[i] = 1'b1;
          end else if (in_pulse[i] && level[i]) begin
            esum = echo_us[i] + tick_us;
            echo_us[i] = esum[TimeW] ? '1 : esum[TimeW-1:0];
          end else if (in_pulse[i] && !level[i]) begin
            in_pulse[i] = 1'b0;
            prod = echo_us[i] * scale;
            prod = prod >> ScaleShift;
            dist_cm[i] = (prod > DistMax) ? DistWidth'(DistMax) : prod[DistWidth-1:0];
            r.done[i] = 1'b1;
            n_latched++;
          end
        end
        rsum = resp_us + tick_us;
        resp_us = rsum[RespWidth] ? '1 : rsum[RespWidth-1:0];
      end
      r.cm        = dist_cm;
      r.listening = listen;
      ranging_q.push_back(r);
    endfunction

    function void check_result(ranging_result_t got);
      ranging_result_t want;
      string lanes;
      lanes = "abc";
      n_checked++;
      if (ranging_q.size() == 0) begin
        $error("result transfer with no item pending: %h", got);
        failures++;
        return;
      end
      want = ranging_q.pop_front();
      for (int i = 0; i < NumLanes; i++) begin
        if (got.cm[i] !== want.cm[i]) begin
          $error("distance_%s: expected %0d, actual %0d", lanes.substr(i, i),
                 want.cm[i], got.cm[i]);
          failures++;
        end
        if (got.done[i] !== want.done[i]) begin
          $error("done_%s: expected %0d, actual %0d", lanes.substr(i, i),
                 want.done[i], got.done[i]);
          failures++;
        end
      end
      if (got.listening !== want.listening) begin
        $error("listening: expected %0d, actual %0d", want.listening, got.listening);
        failures++;
      end
    endfunction

    function int pending();
      return ranging_q.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic kind = 1'b0;
  logic [NumLanes-1:0] echo = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [DistWidth-1:0] distance_a, distance_b, distance_c;
  logic done_a, done_b, done_c, listening;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CfgIdxWidth-1:0] cfg_index = '0;
  logic [CfgDataWidth-1:0] cfg_data = '0;

  ranging_scoreboard sb = new();
  int unsigned n_items = 0;
  int unsigned n_settings = 0;
  bit quiet = 1'b0;
  bit hold_req = 1'b0;

  ultrasonic_echo_ranging dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .kind_i      (kind),
    .echo_a_i    (echo[0]),
    .echo_b_i    (echo[1]),
    .echo_c_i    (echo[2]),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .distance_a_o(distance_a),
    .distance_b_o(distance_b),
    .distance_c_o(distance_c),
    .done_a_o    (done_a),
    .done_b_o    (done_b),
    .done_c_o    (done_c),
    .listening_o (listening),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("ultrasonic_echo_ranging test failed");
    $finish;
  end

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // receiver: random stalls, one long hold-off on request
  initial begin
    int len;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
      end else if (quiet) begin
        out_stall <= 1'b0;
        @(posedge clk_i);
      end else begin
        out_stall <= ($urandom_range(0, 2) == 0);
        len = rand_gap();
        repeat (len + 1) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      sb.check_result('{cm: {distance_c, distance_b, distance_a},
                        done: {done_c, done_b, done_a}, listening: listening});
    end
  end

  task automatic send_item(logic k, logic [NumLanes-1:0] lvl);
    int gap;
    gap = rand_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    kind     <= k;
    echo     <= lvl;
    do @(posedge clk_i); while (in_stall);
    sb.note_input(k, lvl);
    n_items++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgDataWidth-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready);
    sb.write_reg(idx, data);
  endtask

  task automatic configure(logic [TickWidth-1:0] tick_us, logic [RespWidth-1:0] limit_us,
                           logic [ScaleWidth-1:0] scale);
    write_reg(CFG_TICK_PERIOD, {{(CfgDataWidth-TickWidth){1'b0}}, tick_us});
    write_reg(CFG_TIMEOUT, limit_us);
    write_reg(CFG_SCALE, scale);
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  // trigger, then one pulse per channel with random start and width, light noise
  task automatic run_ping(int forced_len);
    int start[NumLanes];
    int width[NumLanes];
    int n_ticks;
    logic [NumLanes-1:0] lvl;
    n_ticks = 0;
    for (int i = 0; i < NumLanes; i++) begin
      start[i] = $urandom_range(0, 4);
      if (forced_len > 0) width[i] = forced_len;
      else if ($urandom_range(0, 19) == 0) width[i] = $urandom_range(30, 120);
      else width[i] = $urandom_range(0, 12);
      if (start[i] + width[i] + 1 > n_ticks) n_ticks = start[i] + width[i] + 1;
    end
    n_ticks += $urandom_range(0, 3);
    send_item(KindTrigger, NumLanes'($urandom_range(0, 7)));
    for (int t = 0; t < n_ticks; t++) begin
      for (int i = 0; i < NumLanes; i++) lvl[i] = (t >= start[i]) && (t < start[i] + width[i]);
      if ($urandom_range(0, 24) == 0) lvl ^= NumLanes'(1 << $urandom_range(0, NumLanes-1));
      send_item(KindTick, lvl);
    end
  endtask

  task automatic run_phase(logic [TickWidth-1:0] tick_us, logic [RespWidth-1:0] limit_us,
                           logic [ScaleWidth-1:0] scale, int forced_len);
    int unsigned first;
    drain();
    configure(tick_us, limit_us, scale);
    first = n_items;
    if (forced_len > 0) run_ping(forced_len);
    while (n_items - first < PhaseItems) begin
      if ($urandom_range(0, 4) == 0) begin
        send_item(1'($urandom_range(0, 1)), NumLanes'($urandom_range(0, 7)));
      end else begin
        run_ping(0);
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: idle tick, ignored levels on trigger, pulse kept across trigger
    send_item(KindTick, 3'b111);
    send_item(KindTrigger, 3'b111);
    send_item(KindTick, 3'b111);
    send_item(KindTick, 3'b111);
    send_item(KindTick, 3'b101);
    send_item(KindTick, 3'b010);
    send_item(KindTrigger, 3'b000);
    send_item(KindTick, 3'b010);
    send_item(KindTick, 3'b000);
    send_item(KindTick, 3'b000);
    drain();

    // zero timeout: listening drops on the second tick, later ticks ignored
    configure(8'd255, 16'd0, 16'hFFFF);
    send_item(KindTrigger, 3'b101);
    send_item(KindTick, 3'b111);
    send_item(KindTick, 3'b111);
    send_item(KindTick, 3'b000);
    send_item(KindTrigger, 3'b000);
    send_item(KindTick, 3'b000);
    drain();

    // zero tick period: times stay put
    configure(8'd0, 16'd100, 16'd1000);
    send_item(KindTrigger, 3'b010);
    send_item(KindTick, 3'b111);
    send_item(KindTick, 3'b111);
    send_item(KindTick, 3'b000);

    // long ping saturates echo time, response timer and distance
    run_phase(8'd255, 16'hFFFF, 16'hFFFF, 300);
    run_phase(8'd1, 16'd0, 16'd0, 0);
    drain();
    quiet = 1'b1;
    hold_req = 1'b1;
    run_phase(TickPeriodReset, TimeoutReset, ScaleReset, 0);
    quiet = 1'b0;
    run_phase(8'd255, 16'd3000, 16'd40000, 0);
    run_phase(8'd1, 16'hFFFF, 16'hFFFF, 0);
    repeat (3) begin
      run_phase(TickWidth'($urandom_range(1, 255)), RespWidth'($urandom_range(0, 65535)),
                ScaleWidth'($urandom_range(0, 65535)), 0);
    end
    drain();

    $display("Ran %0d items through %0d register settings, %0d results checked.",
             n_items, n_settings, sb.n_checked);
    $display("Saw %0d latched distances and %0d listening timeouts.",
             sb.n_latched, sb.n_timeouts);
    if (sb.failures == 0) begin
      $display("ultrasonic_echo_ranging test passed");
    end else begin
      $display("ultrasonic_echo_ranging test failed");
    end
    $finish;
  end

endmodule
